### rtl/u2u_pkg.sv
// Shared types and helpers for the UTF-8 to UTF-16 transcoder.
// Holds the queue entry format and the surrogate-pair formulas; no dependencies.
package u2u_pkg;

    localparam int PointWidth = 21;
    localparam int UnitWidth  = 16;

    localparam logic [PointWidth-1:0] SuppBase      = 21'h10000;
    localparam logic [UnitWidth-1:0]  HighSurrogate = 16'hD800;
    localparam logic [UnitWidth-1:0]  LowSurrogate  = 16'hDC00;

    localparam logic [1:0] ContTag = 2'b10;

    typedef struct packed {
        logic                  is_error;
        logic                  eos;
        logic [PointWidth-1:0] point;
    } entry_t;

    function automatic logic [UnitWidth-1:0] surr_high(input logic [PointWidth-1:0] cp);
        logic [PointWidth-1:0] v;
        v = cp - SuppBase;
        return UnitWidth'(v >> 10) | HighSurrogate;
    endfunction

    function automatic logic [UnitWidth-1:0] surr_low(input logic [PointWidth-1:0] cp);
        logic [PointWidth-1:0] v;
        v = cp - SuppBase;
        return {6'b0, v[9:0]} | LowSurrogate;
    endfunction

endpackage

### rtl/utf8_to_utf16_transcoder_unit.sv
// Top level of the UTF-8 to UTF-16 transcoder.
// Instantiates u2u_front, u2u_queue and u2u_back; uses u2u_pkg.
//
// The block takes one UTF-8 byte per cycle whenever in_stall is low, which is
// the case while the entry queue (QUEUE_DEPTH entries) has room. Each byte
// that completes a code point, raises an error or ends a discarded string puts
// one entry in the queue; the output register drains it as one code unit per
// cycle while out_stall is low, and a supplementary code point leaves as a
// surrogate pair. A result goes through the queue and then the output register.
// Error results carry code_unit zero and mark the string for discard; the
// remaining bytes of that string give no results until its end.
module utf8_to_utf16_transcoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_of_string,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] code_unit,
    output logic        error,
    output logic        last_of_item,
    output logic        last_of_string
);

    logic            queue_full;
    logic            push;
    logic            pop;
    logic            head_valid;
    u2u_pkg::entry_t push_data;
    u2u_pkg::entry_t head;

    u2u_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .queue_full    (queue_full),
        .push          (push),
        .push_data     (push_data)
    );

    u2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    u2u_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .code_unit      (code_unit),
        .error          (error),
        .last_of_item   (last_of_item),
        .last_of_string (last_of_string)
    );

endmodule

### rtl/u2u_front.sv
// Front end of the transcoder: accepts bytes, tracks sequence state, pushes entries.
// Depends on u2u_pkg for the entry format.
module u2u_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      in_byte,
    input  logic            end_of_string,
    input  logic            queue_full,
    output logic            push,
    output u2u_pkg::entry_t push_data
);

    logic [1:0]                       pending_reg, pending_next;
    logic [u2u_pkg::PointWidth-1:0]   accum_reg, accum_next;
    logic                             discard_reg, discard_next;
    logic                             accept;
    logic                             produce;
    logic                             raise;
    logic [u2u_pkg::PointWidth-1:0]   cont_accum;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign push     = accept && produce;
    assign cont_accum = {accum_reg[u2u_pkg::PointWidth-7:0], in_byte[5:0]};

    always_comb
    begin
        pending_next = pending_reg;
        accum_next   = accum_reg;
        discard_next = discard_reg;
        produce      = 1'b0;
        raise        = 1'b0;
        push_data.is_error = 1'b0;
        push_data.eos      = end_of_string;
        push_data.point    = '0;

        if (discard_reg)
        begin
            if (end_of_string)
            begin
                produce = 1'b1;
                push_data.is_error = 1'b1;
                discard_next = 1'b0;
                pending_next = '0;
                accum_next   = '0;
            end
        end
        else if (pending_reg != 2'd0)
        begin
            if (in_byte[7:6] != u2u_pkg::ContTag)
            begin
                raise = 1'b1;
            end
            else if (pending_reg == 2'd1)
            begin
                produce = 1'b1;
                push_data.point = cont_accum;
                pending_next = '0;
                accum_next   = '0;
            end
            else if (end_of_string)
            begin
                raise = 1'b1;
            end
            else
            begin
                pending_next = pending_reg - 2'd1;
                accum_next   = cont_accum;
            end
        end
        else
        begin
            if (!in_byte[7])
            begin
                produce = 1'b1;
                push_data.point = {13'b0, in_byte};
            end
            else if (in_byte[7:6] == u2u_pkg::ContTag || in_byte[7:3] == 5'b11111)
            begin
                raise = 1'b1;
            end
            else if (end_of_string)
            begin
                raise = 1'b1;
            end
            else if (!in_byte[5])
            begin
                pending_next = 2'd1;
                accum_next   = {16'b0, in_byte[4:0]};
            end
            else if (!in_byte[4])
            begin
                pending_next = 2'd2;
                accum_next   = {17'b0, in_byte[3:0]};
            end
            else
            begin
                pending_next = 2'd3;
                accum_next   = {18'b0, in_byte[2:0]};
            end
        end

        if (raise)
        begin
            produce = 1'b1;
            push_data.is_error = 1'b1;
            push_data.point    = '0;
            pending_next = '0;
            accum_next   = '0;
            discard_next = !end_of_string;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            accum_reg   <= '0;
            discard_reg <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            accum_reg   <= accum_next;
            discard_reg <= discard_next;
        end
    end

endmodule

### rtl/u2u_queue.sv
// Short entry queue between the front end and the unit emitter.
// Depends on u2u_pkg for the entry format.
module u2u_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u2u_pkg::entry_t push_data,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output u2u_pkg::entry_t head
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u2u_pkg::entry_t slot_reg [DEPTH];
    logic [IW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
        return (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/u2u_back.sv
// Back end of the transcoder: turns queue entries into UTF-16 code units.
// Depends on u2u_pkg for the entry format and surrogate helpers.
module u2u_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             head_valid,
    input  u2u_pkg::entry_t                  head,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [u2u_pkg::UnitWidth-1:0]    code_unit,
    output logic                             error,
    output logic                             last_of_item,
    output logic                             last_of_string
);

    logic                          valid_reg;
    logic                          phase_reg, phase_next;
    logic [u2u_pkg::UnitWidth-1:0] unit_reg, unit_next;
    logic                          err_reg, err_next;
    logic                          item_reg, item_next;
    logic                          str_reg, str_next;
    logic                          load;
    logic                          big;

    assign load = !valid_reg || !out_stall;
    assign big  = |head.point[u2u_pkg::PointWidth-1:16];

    always_comb
    begin
        phase_next = phase_reg;
        unit_next  = head.point[u2u_pkg::UnitWidth-1:0];
        err_next   = 1'b0;
        item_next  = 1'b1;
        str_next   = head.eos;
        pop        = 1'b0;
        if (head.is_error)
        begin
            unit_next = '0;
            err_next  = 1'b1;
            pop       = load && head_valid;
        end
        else if (big && !phase_reg)
        begin
            unit_next  = u2u_pkg::surr_high(head.point);
            item_next  = 1'b0;
            str_next   = 1'b0;
            phase_next = 1'b1;
        end
        else if (big)
        begin
            unit_next  = u2u_pkg::surr_low(head.point);
            phase_next = 1'b0;
            pop        = load && head_valid;
        end
        else
        begin
            pop = load && head_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= head_valid;
            if (head_valid)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            unit_reg <= unit_next;
            err_reg  <= err_next;
            item_reg <= item_next;
            str_reg  <= str_next;
        end
    end

    assign out_valid      = valid_reg;
    assign code_unit      = unit_reg;
    assign error          = err_reg;
    assign last_of_item   = item_reg;
    assign last_of_string = str_reg;

endmodule

### rtl/u2u_checker.sv
// Port-level checks for the UTF-8 to UTF-16 transcoder, bound to its top level.
// Depends only on the top level's port list.
module u2u_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] code_unit,
    input logic        error,
    input logic        last_of_item,
    input logic        last_of_string
);

    a_error_unit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> code_unit == 16'h0000 && last_of_item)
        else $error("error result with nonzero unit or not last of item");

    a_string_end_closes_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_string |-> last_of_item)
        else $error("string ended in the middle of an item");

    a_first_is_high_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_item |-> code_unit[15:11] == 5'b11011 && !error)
        else $error("first unit of a pair is not a high surrogate");

    a_pair_completes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_item |=>
            out_valid && code_unit[15:10] == 6'b110111)
        else $error("high surrogate not followed by low surrogate");

    a_stalled_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_unit) && $stable(error))
        else $error("stalled result changed");

endmodule

bind utf8_to_utf16_transcoder_unit u2u_checker u_u2u_checker (.*);
